@@ rtl/swls_pkg.sv @@
// Types and constants shared by the string word load/store unit.
// No dependencies.
`default_nettype none

package swls_pkg;

  localparam int RegCount   = 32;
  localparam int LaneW      = 2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  reg_number;
    logic [31:0] base_address;
    logic [6:0]  byte_index;
    logic [7:0]  load_byte;
    logic [31:0] write_value;
  } swls_req_t;

  typedef struct packed {
    logic [31:0] mem_address;
    logic        mem_write;
    logic [7:0]  store_byte;
    logic [4:0]  touched_register;
    logic [31:0] register_value;
  } swls_rsp_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } swls_wr_t;

endpackage

`default_nettype wire

@@ rtl/swls_regfile.sv @@
// 32 x 32 register file: synchronous memory with a registered read port.
// Per-entry valid bits give zero after reset; write-to-read bypass. Uses swls_pkg.
`default_nettype none

module swls_regfile (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [4:0]               rd_addr,
  output logic [31:0]                   rd_data,
  input  wire swls_pkg::swls_wr_t       wr
);
  import swls_pkg::*;

  logic [31:0]         mem [RegCount];
  logic [RegCount-1:0] valid;
  logic [31:0]         mem_q;
  logic                valid_q;
  logic                bypass;
  logic [31:0]         bypass_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q       <= mem[rd_addr];
      bypass_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      bypass  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
        bypass  <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  assign rd_data = bypass ? bypass_data : (valid_q ? mem_q : 32'd0);

endmodule

`default_nettype wire

@@ rtl/swls_beat_unit.sv @@
// Byte lane merge/extract for one item, given the register's old value.
// Produces the response and the write-back. Uses swls_pkg.
`default_nettype none

module swls_beat_unit (
  input  wire swls_pkg::swls_req_t  req,
  input  wire logic [4:0]           target,
  input  wire logic [31:0]          old_value,
  output swls_pkg::swls_rsp_t       rsp,
  output logic [31:0]               new_value,
  output logic                      write_back
);
  import swls_pkg::*;

  logic [LaneW-1:0] lane;
  logic [4:0]       shift;
  logic [31:0]      lane_base;
  logic             is_beat;

  assign lane    = req.byte_index[LaneW-1:0];
  assign shift   = {~lane, 3'b000};
  assign is_beat = (req.operation == OP_LOAD) || (req.operation == OP_STORE);
  assign lane_base = (lane == '0) ? 32'd0 : old_value;

  always_comb begin
    new_value  = old_value;
    write_back = 1'b0;
    case (req.operation)
      OP_LOAD: begin
        new_value  = lane_base | ({24'd0, req.load_byte} << shift);
        write_back = 1'b1;
      end
      OP_WRITE: begin
        new_value  = req.write_value;
        write_back = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.mem_address      = is_beat ? req.base_address + {25'd0, req.byte_index} : 32'd0;
    rsp.mem_write        = (req.operation == OP_STORE);
    rsp.store_byte       = (req.operation == OP_STORE) ? 8'(old_value >> shift) : 8'd0;
    rsp.touched_register = target;
    rsp.register_value   = new_value;
  end

endmodule

`default_nettype wire

@@ rtl/string_word_load_store_unit_top.sv @@
// Top level of the string word load/store unit: register file, beat unit,
// item stage and output register. Uses swls_pkg, swls_regfile, swls_beat_unit.
//
//   channel   | handshake                       | payload
//   request   | request_valid / request_ready   | request  (swls_req_t)
//   response  | response_valid / response_ready | response (swls_rsp_t)
//
// One item per cycle sustained while the response is not stalled; an item goes
// from the item stage to the response register via the registered read port.
// The read is issued on acceptance, the write-back happens when the item
// leaves the stage, and a write to the entry being read is bypassed.
// Reset clears the valid bits of all 32 registers at once (they read zero).
// A stalled response holds the item stage; one item waits there.
`default_nettype none

module string_word_load_store_unit_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 request_valid,
  output logic                      request_ready,
  input  wire swls_pkg::swls_req_t  request,
  output logic                      response_valid,
  input  wire logic                 response_ready,
  output swls_pkg::swls_rsp_t       response
);
  import swls_pkg::*;

  logic       busy;
  swls_req_t  stage;
  logic [4:0] stage_target;
  logic [4:0] target_next;
  logic       finish;
  logic       accept;
  logic [31:0] old_value;
  logic [31:0] new_value;
  logic        write_back;
  swls_rsp_t   rsp_next;
  swls_wr_t    wr;

  assign finish        = busy && (!response_valid || response_ready);
  assign request_ready = !rst && (!busy || finish);
  assign accept        = request_valid && request_ready;

  always_comb begin
    if ((request.operation == OP_LOAD) || (request.operation == OP_STORE)) begin
      target_next = request.reg_number + request.byte_index[6:2];
    end else begin
      target_next = request.reg_number;
    end
  end

  swls_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (target_next),
    .rd_data (old_value),
    .wr      (wr)
  );

  swls_beat_unit u_beat (
    .req        (stage),
    .target     (stage_target),
    .old_value  (old_value),
    .rsp        (rsp_next),
    .new_value  (new_value),
    .write_back (write_back)
  );

  assign wr.en   = finish && write_back;
  assign wr.addr = stage_target;
  assign wr.data = new_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      response_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        response_valid <= 1'b1;
      end else if (response_ready) begin
        response_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage        <= request;
      stage_target <= target_next;
    end
    if (finish) begin
      response <= rsp_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/swls_checker.sv @@
// Port-level checks for string_word_load_store_unit_top, bound to the top.
// Uses swls_pkg.
`default_nettype none

module swls_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 request_valid,
  input wire logic                 request_ready,
  input wire logic                 response_valid,
  input wire logic                 response_ready,
  input wire swls_pkg::swls_rsp_t  response
);
  import swls_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    response_valid && !response_ready |=> response_valid && $stable(response))
    else $error("response changed while stalled");

  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(response_valid) |-> $past(response_ready))
    else $error("response dropped without being taken");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !response_valid)
    else $error("response valid after reset");

  a_rise_follows_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(response_valid) |-> $past(request_valid && request_ready, 2))
    else $error("response without an accepted item");

  a_store_byte_zero: assert property (@(posedge clk) disable iff (rst)
    response_valid && !response.mem_write |-> response.store_byte == 8'd0)
    else $error("store byte set on a non-store item");

endmodule

bind string_word_load_store_unit_top swls_checker u_swls_checker (
  .clk            (clk),
  .rst            (rst),
  .request_valid  (request_valid),
  .request_ready  (request_ready),
  .response_valid (response_valid),
  .response_ready (response_ready),
  .response       (response)
);

`default_nettype wire
